// ===== hw/rtl/window_max_minus_min_3x3_assert.svh =====
// Assertion macros shared by the window gradient RTL.
// Expects clk and rst_n in scope at the point of use.
`ifndef WINDOW_MAX_MINUS_MIN_3X3_ASSERT_SVH
`define WINDOW_MAX_MINUS_MIN_3X3_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define WMM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define WMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/wmm_pkg.sv =====
// Shared types, constants and helpers for the 3x3 window gradient block.
// No dependencies; imported by the interfaces, wmm_cell and the top module.
`default_nettype none

package wmm_pkg;

  localparam int PIX_W      = 8;
  localparam int LINE_DEPTH = 1024;
  localparam int ROW_DEPTH  = 1024;
  localparam int COL_W      = $clog2(LINE_DEPTH);
  localparam int ROW_W      = $clog2(ROW_DEPTH);
  localparam int CFG_W      = 11;
  localparam int MIN_SIZE   = 3;
  localparam int REG_IDX_W  = 1;

  localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  // Max and min of a group of samples.
  typedef struct packed {
    logic [PIX_W-1:0] hi;
    logic [PIX_W-1:0] lo;
  } span_t;

  function automatic span_t span3(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
                                  input logic [PIX_W-1:0] c);
    span_t s;
    s.hi = (a > b) ? a : b;
    s.hi = (c > s.hi) ? c : s.hi;
    s.lo = (a < b) ? a : b;
    s.lo = (c < s.lo) ? c : s.lo;
    return s;
  endfunction

  // Clamp a size register to [MIN_SIZE, depth] and return the last index.
  function automatic logic [CFG_W-1:0] last_index(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W-1:0] depth);
    logic [CFG_W-1:0] lim;
    if (v < CFG_W'(MIN_SIZE)) begin
      lim = CFG_W'(MIN_SIZE);
    end else if (v > depth) begin
      lim = depth;
    end else begin
      lim = v;
    end
    return lim - CFG_W'(1);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/wmm_pix_if.sv =====
// Pixel request channel: valid/ready handshake with pixel and frame_start.
// Depends on wmm_pkg.
`default_nettype none

interface wmm_pix_if import wmm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/wmm_res_if.sv =====
// Result request channel: valid/ready handshake with gradient and center position.
// Depends on wmm_pkg.
`default_nettype none

interface wmm_res_if import wmm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] gradient;
  logic [COL_W-1:0] center_col;
  logic [ROW_W-1:0] center_row;
  logic             last_in_frame;

  modport source (output valid, output gradient, output center_col, output center_row,
                  output last_in_frame, input ready);
  modport sink   (input valid, input gradient, input center_col, input center_row,
                  input last_in_frame, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/wmm_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module wmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hw/rtl/wmm_cell.sv =====
// One window column cell: stores a column's max/min, hands it to the next
// cell on each shift and folds it into the running window span. Uses wmm_pkg.
`default_nettype none

module wmm_cell import wmm_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  shift,
  input  wire span_t col_in,
  input  wire span_t acc_in,
  output span_t      col_out,
  output span_t      acc_out
);

  span_t col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (shift) begin
      col_r <= col_in;
    end
  end

  assign col_out    = col_r;
  assign acc_out.hi = (col_r.hi > acc_in.hi) ? col_r.hi : acc_in.hi;
  assign acc_out.lo = (col_r.lo < acc_in.lo) ? col_r.lo : acc_in.lo;

endmodule

`default_nettype wire

// ===== hw/rtl/window_max_minus_min_3x3.sv =====
// 3x3 morphological gradient (window max minus min) over a raster pixel stream.
// Uses wmm_pkg, wmm_pix_if, wmm_res_if, wmm_ram, wmm_cell and the assert header.
//
// Usage:
//   in_chan  : one grayscale pixel per request, raster order; frame_start=1
//              marks column 0 / row 0 and restarts the position counters.
//   out_chan : one result per interior pixel (neither first/last row nor
//              first/last column): gradient, center column/row, and
//              last_in_frame on the final interior result of the frame.
//   cfg_*    : image_width (index 0) and image_height (index 1), written only
//              while idle; values are clamped to 3..1024.
// Timing: one pixel per clock sustained while out_chan is not stalled. A result is
//   registered once its window's last pixel leaves stage 1 (line-store read at the
//   accepting edge, then the cell chain into the output register). The line
//   stores are one RAM with a registered read; back-to-back reads of an
//   address just written are forwarded.
// Reset: positions restart at (0,0), window cells clear to zero, size
//   registers return to 1024. Line store contents are undefined until written.
// Stall: while out_chan is stalled the output register holds its result; border
//   pixels still pass, and in_chan.ready drops once an interior pixel waits.
`default_nettype none
`include "window_max_minus_min_3x3_assert.svh"

module window_max_minus_min_3x3 import wmm_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [REG_IDX_W-1:0] cfg_idx,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  wmm_pix_if.sink                   in_chan,
  wmm_res_if.source                 out_chan
);

  // Configuration, stored as clamped last indexes.
  logic [COL_W-1:0] wlast_r;
  logic [ROW_W-1:0] hlast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlast_r <= COL_W'(LINE_DEPTH - 1);
      hlast_r <= ROW_W'(ROW_DEPTH - 1);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_WIDTH:  wlast_r <= COL_W'(last_index(cfg_wdata, CFG_W'(LINE_DEPTH)));
        REG_HEIGHT: hlast_r <= ROW_W'(last_index(cfg_wdata, CFG_W'(ROW_DEPTH)));
        default: ;
      endcase
    end
  end

  // Position of the next pixel.
  logic [COL_W-1:0] col_r, col_nxt, col_cur;
  logic [ROW_W-1:0] row_r, row_nxt, row_cur;
  logic             col_end, row_end;

  // Stage 1: pixel waiting on its line-store read.
  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_px_r;
  logic [COL_W-1:0] s1_c_r;
  logic [ROW_W-1:0] s1_r_r;
  logic             s1_fwd_r;
  logic [PIX_W-1:0] wr_up_r, wr_mid_r;

  // Output register.
  logic             out_valid_r;
  logic [PIX_W-1:0] grad_r;
  logic [COL_W-1:0] ccol_r;
  logic [ROW_W-1:0] crow_r;
  logic             last_r;

  logic                 in_ready, in_acc, s1_fire, s1_inner, s1_last;
  logic [2*PIX_W-1:0]   line_rd;
  logic [PIX_W-1:0]     col_up, col_mid;
  span_t                col_cur_span, acc0, win, col0;

  assign col_cur = in_chan.frame_start ? '0 : col_r;
  assign row_cur = in_chan.frame_start ? '0 : row_r;
  assign col_end = (col_cur >= wlast_r);
  assign row_end = (row_cur >= hlast_r);

  always_comb begin
    if (col_end) begin
      col_nxt = '0;
      row_nxt = row_end ? '0 : row_cur + ROW_W'(1);
    end else begin
      col_nxt = col_cur + COL_W'(1);
      row_nxt = row_cur;
    end
  end

  assign s1_inner = (s1_c_r >= COL_W'(2)) && (s1_r_r >= ROW_W'(2));
  assign s1_last  = (s1_c_r >= wlast_r) && (s1_r_r >= hlast_r);
  assign s1_fire  = s1_valid_r && (!s1_inner || !out_valid_r || out_chan.ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_acc   = in_chan.valid && in_ready;
  assign in_chan.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
      s1_fwd_r   <= 1'b0;
    end else begin
      if (in_acc) begin
        col_r      <= col_nxt;
        row_r      <= row_nxt;
        s1_valid_r <= 1'b1;
        // previous item writes this address at the same edge: RAM read misses it
        s1_fwd_r   <= s1_fire && (s1_c_r == col_cur);
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
        s1_fwd_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px_r <= in_chan.pixel;
      s1_c_r  <= col_cur;
      s1_r_r  <= row_cur;
    end
    if (s1_fire) begin
      wr_up_r  <= col_mid;
      wr_mid_r <= s1_px_r;
    end
  end

  // Upper and middle line stores share one RAM word: {upper, middle}.
  wmm_ram #(
    .WIDTH(2*PIX_W),
    .DEPTH(LINE_DEPTH)
  ) u_lines (
    .clk  (clk),
    .we   (s1_fire),
    .waddr(s1_c_r),
    .wdata({col_mid, s1_px_r}),
    .re   (in_acc),
    .raddr(col_cur),
    .rdata(line_rd)
  );

  assign col_up  = s1_fwd_r ? wr_up_r  : line_rd[2*PIX_W-1:PIX_W];
  assign col_mid = s1_fwd_r ? wr_mid_r : line_rd[PIX_W-1:0];

  assign col_cur_span = span3(col_up, col_mid, s1_px_r);

  // Cell 0 holds the previous column, cell 1 the one before it.
  wmm_cell u_cell0 (
    .clk    (clk),
    .rst_n  (rst_n),
    .shift  (s1_fire),
    .col_in (col_cur_span),
    .acc_in (col_cur_span),
    .col_out(col0),
    .acc_out(acc0)
  );

  wmm_cell u_cell1 (
    .clk    (clk),
    .rst_n  (rst_n),
    .shift  (s1_fire),
    .col_in (col0),
    .acc_in (acc0),
    .col_out(),
    .acc_out(win)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (s1_fire && s1_inner) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_inner) begin
      grad_r <= win.hi - win.lo;
      ccol_r <= s1_c_r - COL_W'(1);
      crow_r <= s1_r_r - ROW_W'(1);
      last_r <= s1_last;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.gradient      = grad_r;
  assign out_chan.center_col    = ccol_r;
  assign out_chan.center_row    = crow_r;
  assign out_chan.last_in_frame = last_r;

  `WMM_ASSERT_NEXT(a_inner_gives_result, s1_fire && s1_inner, out_valid_r,
                   "interior pixel lost its result")
  `WMM_ASSERT_NEXT(a_frame_start_pos, in_acc && in_chan.frame_start,
                   (col_r == COL_W'(1)) && (row_r == '0),
                   "frame start did not restart position")
  `WMM_ASSERT_NOW(a_center_interior, out_valid_r, (ccol_r != '0) && (crow_r != '0),
                  "result center on the border")
  `WMM_ASSERT_NOW(a_fwd_needs_item, s1_fwd_r, s1_valid_r,
                  "forward flag without an item")

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking bench for the 3x3 window gradient block: drives pixel frames, predicts each
// interior max-minus-min result and checks it field by field on the result channel.
// Depends on wmm_pkg, wmm_pix_if, wmm_res_if and window_max_minus_min_3x3.
`timescale 1ns / 1ps

module tb_top;
  import wmm_pkg::*;

  localparam int          PIPE_LATENCY = 8;
  localparam int          LONG_STALL   = 300;
  localparam int          RANDOM_ITEMS = 900;
  localparam int          DRAIN_LIMIT  = 20000;
  localparam longint      TIMEOUT_NS   = 4000000;

  typedef struct packed {
    logic [PIX_W-1:0] gradient;
    logic [COL_W-1:0] center_col;
    logic [ROW_W-1:0] center_row;
    logic             last_in_frame;
  } gradient_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  wmm_pix_if pix_chan();
  wmm_res_if res_chan();

  window_max_minus_min_3x3 uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .in_chan  (pix_chan),
    .out_chan (res_chan)
  );

  always #2 clk = ~clk;

  // Predictor state
  logic [CFG_W-1:0] width_reg  = CFG_W'(LINE_DEPTH);
  logic [CFG_W-1:0] height_reg = CFG_W'(ROW_DEPTH);
  logic [PIX_W-1:0] upper_row_store  [LINE_DEPTH];
  logic [PIX_W-1:0] middle_row_store [LINE_DEPTH];
  logic [PIX_W-1:0] window_cols [6];
  int unsigned      next_col = 0;
  int unsigned      next_row = 0;

  gradient_result_t pending_gradients[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_requests = 0;
  int stall_served   = 0;
  int stall_left     = 0;
  int mismatches     = 0;
  int pixels_sent    = 0;
  int results_checked = 0;
  int frame_ends     = 0;
  int size_writes    = 0;

  initial begin
    for (int i = 0; i < LINE_DEPTH; i++) begin
      upper_row_store[i]  = '0;
      middle_row_store[i] = '0;
    end
    for (int i = 0; i < 6; i++) window_cols[i] = '0;
  end

  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  function automatic void predict_gradient(input logic [PIX_W-1:0] px, input logic fs);
    int unsigned      w, h, c, r, i;
    logic [PIX_W-1:0] column [3];
    logic [PIX_W-1:0] hi, lo, v;
    gradient_result_t res;
    w = clamp_dim(width_reg, LINE_DEPTH);
    h = clamp_dim(height_reg, ROW_DEPTH);
    if (fs) begin
      next_col = 0;
      next_row = 0;
    end
    c = next_col;
    r = next_row;
    if (c >= LINE_DEPTH) c = 0;
    column[0] = upper_row_store[c];
    column[1] = middle_row_store[c];
    column[2] = px;
    upper_row_store[c]  = column[1];
    middle_row_store[c] = px;
    if (c >= 2 && r >= 2) begin
      hi = '0;
      lo = '1;
      for (i = 0; i < 9; i++) begin
        v = (i < 6) ? window_cols[i] : column[i-6];
        if (v > hi) hi = v;
        if (v < lo) lo = v;
      end
      res.gradient      = hi - lo;
      res.center_col    = COL_W'(c - 1);
      res.center_row    = ROW_W'(r - 1);
      res.last_in_frame = (c + 1 >= w) && (r + 1 >= h);
      pending_gradients.push_back(res);
    end
    for (i = 0; i < 3; i++) begin
      window_cols[i]   = window_cols[i+3];
      window_cols[i+3] = column[i];
    end
    if (c + 1 >= w) begin
      next_col = 0;
      next_row = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      next_col = c + 1;
      next_row = r;
    end
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    if ($urandom_range(3) == 0) return $urandom_range(1) ? '1 : '0;
    return PIX_W'($urandom);
  endfunction

  // Mostly small frames; now and then out-of-range or wider/taller settings.
  function automatic logic [CFG_W-1:0] rand_size(input bit tall);
    case ($urandom_range(9))
      0: return CFG_W'($urandom_range(0, 2));
      1: return tall ? CFG_W'($urandom_range(1025, 2047)) : CFG_W'($urandom_range(13, 64));
      default: return tall ? CFG_W'($urandom_range(3, 8)) : CFG_W'($urandom_range(3, 12));
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < 40) $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_chan.valid <= 1'b0;
      @(posedge clk);
    end
    pix_chan.valid       <= 1'b1;
    pix_chan.pixel       <= px;
    pix_chan.frame_start <= fs;
    do @(posedge clk); while (!pix_chan.ready);
    predict_gradient(px, fs);
    pixels_sent++;
  endtask

  // Stop requesting, wait for every expected result, then let the pipe empty.
  task automatic settle();
    pix_chan.valid <= 1'b0;
    while (pending_gradients.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  task automatic write_sizes(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_idx   <= REG_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    width_reg  = w;
    height_reg = h;
    size_writes++;
  endtask

  // Receiver: random ready, plus long hold-offs on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      res_chan.ready <= 1'b0;
    end else if (stall_left > 0) begin
      res_chan.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_requests != stall_served) begin
      res_chan.ready <= 1'b0;
      stall_served <= stall_requests;
      stall_left <= LONG_STALL;
    end else begin
      res_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    gradient_result_t want;
    if (rst_n && res_chan.valid && res_chan.ready) begin
      if (pending_gradients.size() == 0) begin
        report_mismatch($sformatf("unexpected gradient %0d at col %0d row %0d",
                                  res_chan.gradient, res_chan.center_col,
                                  res_chan.center_row));
      end else begin
        want = pending_gradients.pop_front();
        results_checked++;
        if (want.last_in_frame) frame_ends++;
        if (res_chan.gradient !== want.gradient)
          report_mismatch($sformatf("gradient %0d, expected %0d at col %0d row %0d",
                                    res_chan.gradient, want.gradient, want.center_col,
                                    want.center_row));
        if (res_chan.center_col !== want.center_col)
          report_mismatch($sformatf("center_col %0d, expected %0d",
                                    res_chan.center_col, want.center_col));
        if (res_chan.center_row !== want.center_row)
          report_mismatch($sformatf("center_row %0d, expected %0d",
                                    res_chan.center_row, want.center_row));
        if (res_chan.last_in_frame !== want.last_in_frame)
          report_mismatch($sformatf("last_in_frame %0b, expected %0b at col %0d row %0d",
                                    res_chan.last_in_frame, want.last_in_frame,
                                    want.center_col, want.center_row));
      end
    end
  end

  // A frame at the reset sizes, cut short inside its first row: no result may appear.
  task automatic test_reset_sizes();
    for (int i = 0; i < 150; i++) send_pixel(rand_pixel(), i == 0);
    settle();
  endtask

  // A 64-wide frame; it writes both line stores at every column the random frames use,
  // so later width growth mid-frame only ever reads written data.
  task automatic test_wide_rows();
    write_sizes(CFG_W'(64), CFG_W'(3));
    for (int i = 0; i < 3 * 64; i++) send_pixel(rand_pixel(), i == 0);
    settle();
  endtask

  // Sizes below the minimum clamp to 3x3; extreme pixels; frame wrap with no start flag.
  task automatic test_small_frames();
    write_sizes(CFG_W'(0), CFG_W'(2));
    for (int i = 0; i < 9; i++) send_pixel((i == 4) ? '0 : '1, i == 0);
    for (int i = 0; i < 9; i++) send_pixel('1, 1'b0);
    settle();
  endtask

  // frame_start in the middle of a frame restarts the position.
  task automatic test_restart();
    send_pixel('0, 1'b0);
    send_pixel('1, 1'b0);
    for (int i = 0; i < 9; i++) send_pixel(i[0] ? '1 : '0, i == 0);
    settle();
  endtask

  // Width shrinks below a position already reached, then grows again mid-frame.
  task automatic test_mid_frame_resize();
    write_sizes(CFG_W'(6), CFG_W'(4));
    for (int i = 0; i < 10; i++) send_pixel(rand_pixel(), i == 0);
    settle();
    write_sizes(CFG_W'(3), CFG_W'(4));
    for (int i = 0; i < 6; i++) send_pixel(rand_pixel(), 1'b0);
    settle();
    write_sizes(CFG_W'(6), CFG_W'(5));
    for (int i = 0; i < 8; i++) send_pixel(rand_pixel(), 1'b0);
    settle();
  endtask

  // Over-range sizes clamp from above: a tall narrow frame keeps its rows going, and a
  // frame cut short inside its first clamped-width row gives no result.
  task automatic test_extreme_sizes();
    write_sizes(CFG_W'(3), CFG_W'(2047));
    for (int i = 0; i < 3 * 40; i++) send_pixel(rand_pixel(), i == 0);
    settle();
    write_sizes(CFG_W'(2047), CFG_W'(3));
    for (int i = 0; i < 200; i++) send_pixel(rand_pixel(), i == 0);
    settle();
  endtask

  // Long receiver hold-off fills the block; then the sender pauses mid-frame until drained.
  task automatic test_backpressure();
    write_sizes(CFG_W'(8), CFG_W'(6));
    stall_requests++;
    for (int i = 0; i < 40; i++) send_pixel(rand_pixel(), i == 0);
    settle();
    for (int i = 0; i < 56; i++) send_pixel(rand_pixel(), 1'b0);
    settle();
  endtask

  task automatic test_random_frames();
    int unsigned seg, sent, npix, resize_at, i;
    bit          with_start;
    for (seg = 0; seg < 3; seg++) begin
      case (seg)
        0: begin send_idle_pct = 28; recv_idle_pct = 50; end
        1: begin send_idle_pct = 50; recv_idle_pct = 28; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      sent = 0;
      while (sent < RANDOM_ITEMS / 3) begin
        if ($urandom_range(3) == 0) begin
          settle();
          write_sizes(rand_size(1'b0), rand_size(1'b1));
        end
        npix = clamp_dim(width_reg, LINE_DEPTH) * clamp_dim(height_reg, ROW_DEPTH);
        // Truncated frames are the noise; oversized frames are always cut short.
        if (npix > 400 || $urandom_range(6) == 0)
          npix = $urandom_range(1, (npix > 400) ? 400 : npix - 1);
        resize_at  = ($urandom_range(9) == 0) ? $urandom_range(1, npix) : 0;
        with_start = ($urandom_range(4) != 0);
        for (i = 0; i < npix; i++) begin
          if (resize_at != 0 && i == resize_at) begin
            settle();
            write_sizes(rand_size(1'b0), rand_size(1'b1));
          end
          send_pixel(rand_pixel(), with_start && i == 0);
        end
        sent += npix;
      end
    end
  endtask

  initial begin
    int guard;
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_idx              <= REG_WIDTH;
    cfg_wdata            <= '0;
    pix_chan.valid       <= 1'b0;
    pix_chan.pixel       <= '0;
    pix_chan.frame_start <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 28;
    recv_idle_pct = 50;
    test_reset_sizes();
    test_wide_rows();
    test_small_frames();
    test_restart();
    test_mid_frame_resize();
    test_extreme_sizes();
    test_backpressure();
    test_random_frames();

    pix_chan.valid <= 1'b0;
    recv_idle_pct = 0;
    for (guard = 0; guard < DRAIN_LIMIT && pending_gradients.size() != 0; guard++)
      @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
    if (pending_gradients.size() != 0)
      report_mismatch($sformatf("%0d expected gradients never arrived",
                                pending_gradients.size()));

    $display("Run covered %0d pixels and %0d checked gradients over %0d frame ends,",
             pixels_sent, results_checked, frame_ends);
    $display("with %0d size settings including clamped and over-range frames.",
             size_writes);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d gradients outstanding", pending_gradients.size());
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== window_max_minus_min_3x3.f =====
+incdir+hw/rtl
hw/rtl/wmm_pkg.sv
hw/rtl/wmm_pix_if.sv
hw/rtl/wmm_res_if.sv
hw/rtl/wmm_ram.sv
hw/rtl/wmm_cell.sv
hw/rtl/window_max_minus_min_3x3.sv
sim/tb_top.sv
